@@ src/dmk_pkg.sv @@
// Shared types and constants for the difference matte alpha unit.
// No dependencies; compiled first.
package dmk_pkg;

   // channel width, Q0.CH_BITS
   localparam int CH_BITS = 16;

   // sum of three absolute differences
   localparam int SUM_BITS = CH_BITS + 2;

   // divide by 3: multiply by ceil(2^RECIP_SHIFT / 3), exact for sums below 2^SUM_BITS
   localparam int RECIP_SHIFT = SUM_BITS + 1;
   localparam int RECIP_BITS  = SUM_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP_THIRD =
      RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3);
   localparam int PROD_BITS = SUM_BITS + RECIP_BITS;

   // one divider cell per quotient bit
   localparam int NUM_CELLS = CH_BITS;

   // configuration port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BIT   = 2;
   localparam logic CSR_IDX_TOLERANCE = 1'b0;
   localparam logic CSR_IDX_FALLOFF   = 1'b1;

   localparam logic [CH_BITS-1:0] TOLERANCE_RESET = CH_BITS'(6554);
   localparam logic [CH_BITS-1:0] FALLOFF_RESET   = CH_BITS'(6554);

   typedef enum logic [1:0] {
      MODE_ZERO,
      MODE_PASS,
      MODE_DIVIDE
   } dmk_mode_type;

   // word handed from cell to cell
   typedef struct packed {
      dmk_mode_type       mode;
      logic [CH_BITS-1:0] rem;
      logic [CH_BITS-1:0] quo;
      logic [CH_BITS-1:0] fall;
      logic [CH_BITS-1:0] alpha;
   } dmk_cell_word_type;

endpackage

@@ src/dmk_req_if.sv @@
// Input channel: image and reference pixel, valid/ready handshake.
// Depends on dmk_pkg.
interface dmk_req_if;
   logic                        valid;
   logic                        ready;
   logic [dmk_pkg::CH_BITS-1:0] image_red;
   logic [dmk_pkg::CH_BITS-1:0] image_green;
   logic [dmk_pkg::CH_BITS-1:0] image_blue;
   logic [dmk_pkg::CH_BITS-1:0] image_alpha;
   logic [dmk_pkg::CH_BITS-1:0] reference_red;
   logic [dmk_pkg::CH_BITS-1:0] reference_green;
   logic [dmk_pkg::CH_BITS-1:0] reference_blue;

   modport source (
      output valid, image_red, image_green, image_blue, image_alpha,
             reference_red, reference_green, reference_blue,
      input  ready
   );
   modport sink (
      input  valid, image_red, image_green, image_blue, image_alpha,
             reference_red, reference_green, reference_blue,
      output ready
   );
endinterface

@@ src/dmk_rsp_if.sv @@
// Result channel: matte alpha, valid/ready handshake.
// Depends on dmk_pkg.
interface dmk_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dmk_pkg::CH_BITS-1:0] matte_alpha;

   modport source (output valid, matte_alpha, input ready);
   modport sink (input valid, matte_alpha, output ready);
endinterface

@@ src/dmk_front.sv @@
// Front end: absolute differences, divide by 3, band classification (3 stages).
// Depends on dmk_pkg and dmk_req_if.
module dmk_front (
   input  logic                        clock,
   input  logic                        reset,
   dmk_req_if.sink                     req_if,
   input  logic [dmk_pkg::CH_BITS-1:0] tolerance,
   input  logic [dmk_pkg::CH_BITS-1:0] falloff_width,
   output logic                        out_valid,
   input  logic                        out_ready,
   output dmk_pkg::dmk_cell_word_type  out_word
);
   import dmk_pkg::*;

   logic                  s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                  s1_ready, s2_ready, s3_ready;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [CH_BITS-1:0]    alpha1_ff, alpha2_ff;
   logic [CH_BITS-1:0]    avg_ff, avg_in;
   logic [PROD_BITS-1:0]  prod;
   dmk_cell_word_type     word_ff, word_in;
   logic [CH_BITS-1:0]    diff_r, diff_g, diff_b;
   logic [CH_BITS:0]      band_top;

   assign s3_ready     = !s3_valid_ff || out_ready;
   assign s2_ready     = !s2_valid_ff || s3_ready;
   assign s1_ready     = !s1_valid_ff || s2_ready;
   assign req_if.ready = s1_ready;
   assign out_valid    = s3_valid_ff;
   assign out_word     = word_ff;

   always_comb begin
      diff_r = (req_if.image_red >= req_if.reference_red) ?
               req_if.image_red - req_if.reference_red :
               req_if.reference_red - req_if.image_red;
      diff_g = (req_if.image_green >= req_if.reference_green) ?
               req_if.image_green - req_if.reference_green :
               req_if.reference_green - req_if.image_green;
      diff_b = (req_if.image_blue >= req_if.reference_blue) ?
               req_if.image_blue - req_if.reference_blue :
               req_if.reference_blue - req_if.image_blue;
      sum_in = SUM_BITS'(diff_r) + SUM_BITS'(diff_g) + SUM_BITS'(diff_b);
   end

   // truncating divide by 3 through the reciprocal
   always_comb begin
      prod   = PROD_BITS'(sum_ff) * PROD_BITS'(RECIP_THIRD);
      avg_in = prod[RECIP_SHIFT +: CH_BITS];
   end

   always_comb begin
      band_top      = {1'b0, tolerance} + {1'b0, falloff_width};
      word_in.rem   = avg_ff - tolerance;
      word_in.quo   = '0;
      word_in.fall  = falloff_width;
      word_in.alpha = alpha2_ff;
      if (avg_ff <= tolerance) begin
         word_in.mode = MODE_ZERO;
      end else if ({1'b0, avg_ff} < band_top) begin
         word_in.mode = MODE_DIVIDE;
      end else begin
         // top of band saturates to full scale, then min with alpha: same as pass
         word_in.mode = MODE_PASS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_if.valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         sum_ff    <= sum_in;
         alpha1_ff <= req_if.image_alpha;
      end
      if (s2_ready) begin
         avg_ff    <= avg_in;
         alpha2_ff <= alpha1_ff;
      end
      if (s3_ready) begin
         word_ff <= word_in;
      end
   end

endmodule

@@ src/dmk_div_cell.sv @@
// One restoring divider cell: produces one quotient bit and passes the word on.
// Depends on dmk_pkg.
module dmk_div_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  dmk_pkg::dmk_cell_word_type in_word,
   output logic                       out_valid,
   input  logic                       out_ready,
   output dmk_pkg::dmk_cell_word_type out_word
);
   import dmk_pkg::*;

   logic              valid_ff;
   dmk_cell_word_type word_ff, word_in;
   logic [CH_BITS:0]  shifted;
   logic [CH_BITS:0]  trial;
   logic              bit_set;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   // remainder stays below fall, so the restored value fits CH_BITS
   always_comb begin
      shifted       = {in_word.rem, 1'b0};
      trial         = shifted - {1'b0, in_word.fall};
      bit_set       = (shifted >= {1'b0, in_word.fall});
      word_in       = in_word;
      word_in.rem   = bit_set ? trial[CH_BITS-1:0] : shifted[CH_BITS-1:0];
      word_in.quo   = {in_word.quo[CH_BITS-2:0], bit_set};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         word_ff <= word_in;
      end
   end

endmodule

@@ src/difference_matte_alpha_unit.sv @@
// Difference matte keyer: matte alpha from an image pixel against a reference pixel.
// Depends on dmk_pkg, dmk_req_if, dmk_rsp_if, dmk_front, dmk_div_cell.
//
// Takes one pixel word per cycle unless backpressure stalls it, and returns one matte
// alpha word per pixel, in order. A pixel passes 20 registers: three front stages
// (differences, divide by 3, band check), a chain of 16 divider cells that each settle
// one quotient bit, and the output register; result valid rises when the pixel
// reaches the output register. Every stage holds its word under backpressure and takes
// a new one as soon as its neighbor moves, so bubbles close up and a stalled output does
// not stop input until all 20 stages are full. Registers: tolerance at byte address 0,
// falloff_width at 4, both 16 bits in the low bits of the 32-bit data, reset to 6554.
// Write them only while no pixel is in flight.
module difference_matte_alpha_unit (
   input  logic                              clock,
   input  logic                              reset,
   dmk_req_if.sink                           req_if,
   dmk_rsp_if.source                         rsp_if,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dmk_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [dmk_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [dmk_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import dmk_pkg::*;

   logic [CH_BITS-1:0] tolerance_ff;
   logic [CH_BITS-1:0] falloff_ff;
   logic               csr_write;

   logic              cell_valid [NUM_CELLS+1];
   logic              cell_ready [NUM_CELLS+1];
   dmk_cell_word_type cell_word  [NUM_CELLS+1];

   logic               rsp_valid_ff;
   logic [CH_BITS-1:0] matte_ff, matte_in;
   logic               out_load;
   dmk_cell_word_type  last_word;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= TOLERANCE_RESET;
         falloff_ff   <= FALLOFF_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[CSR_IDX_BIT])
            CSR_IDX_TOLERANCE: tolerance_ff <= csr_pwdata[CH_BITS-1:0];
            CSR_IDX_FALLOFF:   falloff_ff   <= csr_pwdata[CH_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[CSR_IDX_BIT])
         CSR_IDX_TOLERANCE: csr_prdata = CSR_DATA_BITS'(tolerance_ff);
         CSR_IDX_FALLOFF:   csr_prdata = CSR_DATA_BITS'(falloff_ff);
         default:           csr_prdata = '0;
      endcase
   end

   dmk_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_if),
      .tolerance     (tolerance_ff),
      .falloff_width (falloff_ff),
      .out_valid     (cell_valid[0]),
      .out_ready     (cell_ready[0]),
      .out_word      (cell_word[0])
   );

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      dmk_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[k]),
         .in_ready  (cell_ready[k]),
         .in_word   (cell_word[k]),
         .out_valid (cell_valid[k+1]),
         .out_ready (cell_ready[k+1]),
         .out_word  (cell_word[k+1])
      );
   end

   // output register
   assign last_word              = cell_word[NUM_CELLS];
   assign out_load               = !rsp_valid_ff || rsp_if.ready;
   assign cell_ready[NUM_CELLS]  = out_load;
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.matte_alpha     = matte_ff;

   always_comb begin
      case (last_word.mode)
         MODE_ZERO:   matte_in = '0;
         MODE_PASS:   matte_in = last_word.alpha;
         MODE_DIVIDE: matte_in = (last_word.quo < last_word.alpha) ?
                                 last_word.quo : last_word.alpha;
         default:     matte_in = last_word.alpha;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= cell_valid[NUM_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         matte_ff <= matte_in;
      end
   end

   // divide words always carry a nonzero divisor into the chain
   assert property (@(posedge clock) disable iff (reset)
      cell_valid[0] && cell_word[0].mode == MODE_DIVIDE |-> cell_word[0].fall != '0)
      else $error("divide word entered the cell chain with zero falloff");

   // restoring divider keeps the remainder below the divisor
   assert property (@(posedge clock) disable iff (reset)
      cell_valid[NUM_CELLS] && last_word.mode == MODE_DIVIDE |->
         last_word.rem < last_word.fall)
      else $error("divider remainder not below falloff at chain end");

   // a result word taken this cycle is replaced only by a new chain word
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && !cell_valid[NUM_CELLS] |=> !rsp_if.valid)
      else $error("output register kept a word after it was taken");

endmodule
